// ===== rtl/core/wts_pkg.sv =====
`timescale 1ns / 1ps
// wts_pkg.sv: widths, types, register indexes, shape codes and the sine table
// builder shared by the waveform table sample unit. No dependencies.
package wts_pkg;

    localparam int CODE_W    = 12;
    localparam int SHAPE_W   = 3;
    localparam int CNT_W     = 10;
    localparam int IDX_W     = 9;
    localparam int HALF_W    = 9;
    localparam int QUOT_W    = 15;
    localparam int SLOPE_W   = 12;
    localparam int REM_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 15;
    localparam int SIN_W     = 16;
    localparam int ITER_W    = 4;

    localparam int MAX_POINTS      = 512;
    localparam int SINE_TABLE_SIZE = 512;
    localparam int DIV_STEPS       = 15;
    localparam int CODE_MAX        = 4095;

    typedef logic [CODE_W-1:0]         code_t;
    typedef logic [SHAPE_W-1:0]        shape_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [IDX_W-1:0]          index_t;
    typedef logic [HALF_W-1:0]         half_t;
    typedef logic [QUOT_W-1:0]         quot_t;
    typedef logic [SLOPE_W-1:0]        slope_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic signed [SIN_W-1:0]   sin_t;

    // Register indexes
    localparam cfg_idx_t REG_WAVE_SHAPE  = 2'd0;
    localparam cfg_idx_t REG_DC_LEVEL    = 2'd1;
    localparam cfg_idx_t REG_AMPLITUDE   = 2'd2;
    localparam cfg_idx_t REG_POINT_COUNT = 2'd3;

    // Shape codes; code 7 behaves as off
    localparam shape_t SHAPE_OFF      = 3'd0;
    localparam shape_t SHAPE_SINE     = 3'd1;
    localparam shape_t SHAPE_SQUARE   = 3'd2;
    localparam shape_t SHAPE_TRIANGLE = 3'd3;
    localparam shape_t SHAPE_PULSE    = 3'd4;
    localparam shape_t SHAPE_DC       = 3'd5;
    localparam shape_t SHAPE_SAWTOOTH = 3'd6;

    localparam shape_t RST_WAVE_SHAPE  = SHAPE_SINE;
    localparam code_t  RST_DC_LEVEL    = 12'd2047;
    localparam code_t  RST_AMPLITUDE   = 12'd2047;
    localparam count_t RST_POINT_COUNT = 10'd20;

    // Slopes and sine step derived from the configuration
    typedef struct packed {
        quot_t  step;
        slope_t tri_slope;
        slope_t saw_slope;
        half_t  half;
    } coef_t;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // log2 of the usable sine table length
    function automatic int sine_table_bits(int size);
        int b;
        b = 2;
        while (((2 << b) <= size) && (b < 14))
        begin
            b++;
        end
        return b;
    endfunction

    // round(32768*sin(2*pi*i/2^bits)) for the first quarter, by Taylor series
    function automatic logic [31:0] sine_mag(int i, int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] sum;
        logic [63:0] term;
        x    = (TWO_PI_Q30 * 64'(i) + (64'd1 << (bits - 1))) >> bits;
        x2   = (x * x) >> 30;
        sum  = x;
        term = ((x * x2) >> 30) / 64'd6;     sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd506; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd600; sum = sum + term;
        return 32'((sum + 64'd16384) >> 15);
    endfunction

    // One table entry; positive half saturates at 32767
    function automatic int sine_entry(int t, int bits);
        int n;
        int q;
        int h;
        int r;
        logic [31:0] m;
        n = 1 << bits;
        q = n >> 2;
        h = n >> 1;
        if (t <= q)
        begin
            m = sine_mag(t, bits);
            r = (m > 32'd32767) ? 32767 : int'(m);
        end
        else if (t <= h)
        begin
            m = sine_mag(h - t, bits);
            r = (m > 32'd32767) ? 32767 : int'(m);
        end
        else if (t <= h + q)
        begin
            m = sine_mag(t - h, bits);
            r = -int'(m);
        end
        else
        begin
            m = sine_mag(n - t, bits);
            r = -int'(m);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/wts_sine_rom.sv =====
`timescale 1ns / 1ps
// wts_sine_rom.sv: Q15 sine table with two registered read ports.
// Depends on wts_pkg for the table builder.
module wts_sine_rom #(
    parameter int SINE_TABLE_SIZE = wts_pkg::SINE_TABLE_SIZE,
    parameter int ADDR_W          = wts_pkg::sine_table_bits(SINE_TABLE_SIZE) + 1
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr_lo,
    input  logic [ADDR_W-1:0] addr_hi,
    output wts_pkg::sin_t     data_lo,
    output wts_pkg::sin_t     data_hi
);

    localparam int SineBits = wts_pkg::sine_table_bits(SINE_TABLE_SIZE);
    localparam int SineN    = 1 << SineBits;

    typedef wts_pkg::sin_t rom_t [0:SineN];

    function automatic rom_t build_rom();
        rom_t r;
        for (int t = 0; t <= SineN; t++)
        begin
            r[t] = wts_pkg::SIN_W'(wts_pkg::sine_entry(t, SineBits));
        end
        return r;
    endfunction

    localparam rom_t Rom = build_rom();

    wts_pkg::sin_t rd_lo_reg;
    wts_pkg::sin_t rd_hi_reg;

    always_ff @(posedge clk)
    begin
        rd_lo_reg <= Rom[addr_lo];
        rd_hi_reg <= Rom[addr_hi];
    end

    assign data_lo = rd_lo_reg;
    assign data_hi = rd_hi_reg;

endmodule

// ===== rtl/core/wts_div.sv =====
`timescale 1ns / 1ps
// wts_div.sv: bit-serial restoring divider for the sine step and the two
// ramp slopes. Depends on wts_pkg.
module wts_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  wts_pkg::count_t count,
    input  wts_pkg::code_t  amp,
    output logic            busy,
    output wts_pkg::coef_t  coef
);

    localparam int RemW = wts_pkg::REM_W;

    logic [wts_pkg::ITER_W-1:0] iter_reg;
    wts_pkg::quot_t             num_full_reg;
    wts_pkg::quot_t             num_amp_reg;
    logic [RemW-1:0]            rem_step_reg;
    logic [RemW-1:0]            rem_tri_reg;
    logic [RemW-1:0]            rem_saw_reg;
    wts_pkg::quot_t             q_step_reg;
    wts_pkg::quot_t             q_tri_reg;
    wts_pkg::quot_t             q_saw_reg;
    wts_pkg::count_t            div_n_reg;
    wts_pkg::half_t             half_reg;

    wts_pkg::code_t  amp2;
    logic [RemW:0]   step_next;
    logic [RemW:0]   tri_next;
    logic [RemW:0]   saw_next;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [RemW:0] div_bit(logic [RemW-1:0] rem, logic nb,
                                              logic [RemW-1:0] d);
        logic [RemW:0] trial;
        logic          q;
        trial = {rem, nb};
        q     = 1'b0;
        if (trial >= {1'b0, d})
        begin
            trial = trial - {1'b0, d};
            q     = 1'b1;
        end
        return {q, trial[RemW-1:0]};
    endfunction

    // Doubled amplitude, held at full scale
    assign amp2 = amp[wts_pkg::CODE_W-1] ? wts_pkg::code_t'(wts_pkg::CODE_MAX)
                                         : {amp[wts_pkg::CODE_W-2:0], 1'b0};

    always_comb
    begin
        step_next = div_bit(rem_step_reg, num_full_reg[wts_pkg::QUOT_W-1], div_n_reg);
        tri_next  = div_bit(rem_tri_reg, num_amp_reg[wts_pkg::QUOT_W-1],
                            {1'b0, half_reg});
        saw_next  = div_bit(rem_saw_reg, num_amp_reg[wts_pkg::QUOT_W-1], div_n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (load)
        begin
            iter_reg <= wts_pkg::ITER_W'(wts_pkg::DIV_STEPS);
        end
        else if (iter_reg != '0)
        begin
            iter_reg <= iter_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_full_reg <= wts_pkg::quot_t'(15'h7FFF);
            num_amp_reg  <= wts_pkg::quot_t'(amp2);
            rem_step_reg <= '0;
            rem_tri_reg  <= '0;
            rem_saw_reg  <= '0;
            q_step_reg   <= '0;
            q_tri_reg    <= '0;
            q_saw_reg    <= '0;
            div_n_reg    <= count;
            half_reg     <= count[wts_pkg::CNT_W-1:1];
        end
        else if (iter_reg != '0)
        begin
            num_full_reg <= {num_full_reg[wts_pkg::QUOT_W-2:0], 1'b0};
            num_amp_reg  <= {num_amp_reg[wts_pkg::QUOT_W-2:0], 1'b0};
            rem_step_reg <= step_next[RemW-1:0];
            rem_tri_reg  <= tri_next[RemW-1:0];
            rem_saw_reg  <= saw_next[RemW-1:0];
            q_step_reg   <= {q_step_reg[wts_pkg::QUOT_W-2:0], step_next[RemW]};
            q_tri_reg    <= {q_tri_reg[wts_pkg::QUOT_W-2:0], tri_next[RemW]};
            q_saw_reg    <= {q_saw_reg[wts_pkg::QUOT_W-2:0], saw_next[RemW]};
        end
    end

    assign busy           = (iter_reg != '0);
    assign coef.step      = q_step_reg;
    assign coef.tri_slope = q_tri_reg[wts_pkg::SLOPE_W-1:0];
    assign coef.saw_slope = q_saw_reg[wts_pkg::SLOPE_W-1:0];
    assign coef.half      = half_reg;

endmodule

// ===== rtl/core/waveform_table_sample_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: a word accepted at one rising edge passes six register stages, the
// last being the output, and comes out on sample_code marked by strobe.
// Throughput: one word per clock while busy is low; the sine multiplies and ROM
// set the depth. Reset: registers return to sine, offset 2047, amplitude 2047,
// 20 points; busy then stays high while the serial divider forms the step and
// slopes. Any configuration write raises busy and holds it until the divider is done.
module waveform_table_sample_unit #(
    parameter int SINE_TABLE_SIZE = wts_pkg::SINE_TABLE_SIZE
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  wts_pkg::index_t           sample_index,
    output logic                      strobe,
    output wts_pkg::code_t            sample_code,
    input  logic                      cfg_write,
    input  wts_pkg::cfg_idx_t         cfg_index,
    input  logic [wts_pkg::CODE_W-1:0] cfg_data
);

    localparam int SineBits   = wts_pkg::sine_table_bits(SINE_TABLE_SIZE);
    localparam int AddrW      = SineBits + 1;
    localparam int Shift      = wts_pkg::PHASE_W - SineBits;
    localparam int ProdW      = wts_pkg::SLOPE_W + wts_pkg::IDX_W;
    localparam int PhaseFullW = wts_pkg::QUOT_W + wts_pkg::IDX_W;
    localparam int ClampW     = 24;
    localparam int ScaleW     = 29;
    localparam int MulW       = 32;

    localparam logic signed [ClampW-1:0] CodeMaxS = ClampW'(wts_pkg::CODE_MAX);

    // Configuration registers
    wts_pkg::shape_t wave_shape_reg;
    wts_pkg::code_t  dc_level_reg;
    wts_pkg::code_t  amplitude_reg;
    wts_pkg::count_t point_count_reg;
    logic            recalc_pend_reg;

    // Divider
    wts_pkg::count_t count_eff;
    wts_pkg::coef_t  coef;
    logic            div_busy;

    // Pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic accept;

    // Stage 1: phase and ramp products
    logic [PhaseFullW-1:0]       phase_full;
    logic [wts_pkg::PHASE_W-1:0] phase1_reg;
    logic                        lo_next, mid_next, pk_next;
    logic                        lo1_reg, mid1_reg, pk1_reg;
    wts_pkg::index_t             tri_op;
    logic [ProdW-1:0]            tri_prod1_reg;
    logic [ProdW-1:0]            saw_prod1_reg;

    // Stage 2: table read and non-sine shapes
    logic [AddrW-1:0]            addr_lo, addr_hi;
    wts_pkg::sin_t               rom_lo, rom_hi;
    logic [wts_pkg::PHASE_W-1:0] fract2_reg;
    wts_pkg::code_t              alt_next;
    wts_pkg::code_t              alt2_reg, alt3_reg, alt4_reg, alt5_reg;
    logic signed [ClampW-1:0]    dc_s, amp_s;
    wts_pkg::code_t              a_lo, c_hi;

    // Stage 3 to 6: interpolation, scaling, offset
    logic [wts_pkg::SIN_W-1:0]   wgt;
    logic signed [MulW-1:0]      p_lo_next, p_hi_next;
    logic signed [MulW-1:0]      p_lo3_reg, p_hi3_reg;
    logic signed [MulW-1:0]      sum4;
    wts_pkg::sin_t               sin4_next, sin4_reg;
    logic signed [MulW-1:0]      scale_full;
    logic signed [ScaleW-1:0]    scale5_reg;
    logic signed [ClampW-1:0]    level6;
    wts_pkg::code_t              code6_next, code6_reg;

    function automatic wts_pkg::code_t clamp_code(logic signed [ClampW-1:0] v);
        wts_pkg::code_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > CodeMaxS)
        begin
            r = wts_pkg::code_t'(wts_pkg::CODE_MAX);
        end
        else
        begin
            r = v[wts_pkg::CODE_W-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration port. Any write re-arms the divider on the next cycle.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg  <= wts_pkg::RST_WAVE_SHAPE;
            dc_level_reg    <= wts_pkg::RST_DC_LEVEL;
            amplitude_reg   <= wts_pkg::RST_AMPLITUDE;
            point_count_reg <= wts_pkg::RST_POINT_COUNT;
            recalc_pend_reg <= 1'b1;
        end
        else
        begin
            recalc_pend_reg <= cfg_write;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    wts_pkg::REG_WAVE_SHAPE:
                        wave_shape_reg <= cfg_data[wts_pkg::SHAPE_W-1:0];
                    wts_pkg::REG_DC_LEVEL:
                        dc_level_reg <= cfg_data;
                    wts_pkg::REG_AMPLITUDE:
                        amplitude_reg <= cfg_data;
                    wts_pkg::REG_POINT_COUNT:
                        point_count_reg <= cfg_data[wts_pkg::CNT_W-1:0];
                endcase
            end
        end
    end

    // Clamp the point count to 2..MAX_POINTS; odd counts pass unchanged
    always_comb
    begin
        if (point_count_reg < wts_pkg::count_t'(2))
        begin
            count_eff = wts_pkg::count_t'(2);
        end
        else if (32'(point_count_reg) > wts_pkg::MAX_POINTS)
        begin
            count_eff = wts_pkg::count_t'(wts_pkg::MAX_POINTS);
        end
        else
        begin
            count_eff = point_count_reg;
        end
    end

    wts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (recalc_pend_reg),
        .count (count_eff),
        .amp   (amplitude_reg),
        .busy  (div_busy),
        .coef  (coef)
    );

    // Hold off words while a write lands or the coefficients are stale
    assign busy   = cfg_write | recalc_pend_reg | div_busy;
    assign accept = start & ~busy;

    // ---------------------------------------------------------------------
    // Valid bits travel with the data; the receiver never stalls, so the
    // pipeline simply advances every cycle.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: sine phase (wraps at one turn of 0x8000), half-period flags
    // and the ramp products. The falling triangle edge uses index - half.
    // ---------------------------------------------------------------------
    always_comb
    begin
        phase_full = PhaseFullW'(coef.step) * PhaseFullW'(sample_index);
        lo_next    = sample_index < coef.half;
        mid_next   = {1'b0, sample_index} < {coef.half, 1'b0};
        pk_next    = ({1'b0, sample_index} == {1'b0, coef.half}) ||
                     ({1'b0, sample_index} == ({1'b0, coef.half} + 10'd1));
        tri_op     = lo_next ? sample_index : (sample_index - coef.half);
    end

    always_ff @(posedge clk)
    begin
        phase1_reg    <= phase_full[wts_pkg::PHASE_W-1:0];
        lo1_reg       <= lo_next;
        mid1_reg      <= mid_next;
        pk1_reg       <= pk_next;
        tri_prod1_reg <= ProdW'(coef.tri_slope) * ProdW'(tri_op);
        saw_prod1_reg <= ProdW'(coef.saw_slope) * ProdW'(sample_index);
    end

    // ---------------------------------------------------------------------
    // Stage 2: read the two neighbouring table entries; form every shape
    // other than the sine; those shapes need no multiply from here on.
    // ---------------------------------------------------------------------
    assign addr_lo = {1'b0, phase1_reg[wts_pkg::PHASE_W-1:Shift]};
    assign addr_hi = {1'b0, phase1_reg[wts_pkg::PHASE_W-1:Shift]} + 1'b1;

    wts_sine_rom #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
        .ADDR_W          (AddrW)
    ) u_rom (
        .clk     (clk),
        .addr_lo (addr_lo),
        .addr_hi (addr_hi),
        .data_lo (rom_lo),
        .data_hi (rom_hi)
    );

    assign dc_s  = ClampW'($signed({1'b0, dc_level_reg}));
    assign amp_s = ClampW'($signed({1'b0, amplitude_reg}));
    assign a_lo  = clamp_code(dc_s - amp_s);
    assign c_hi  = clamp_code(dc_s + amp_s);

    always_comb
    begin
        case (wave_shape_reg)
            wts_pkg::SHAPE_SQUARE:
                alt_next = lo1_reg ? c_hi : a_lo;
            wts_pkg::SHAPE_TRIANGLE:
            begin
                if (lo1_reg)
                begin
                    alt_next = clamp_code(ClampW'($signed({1'b0, a_lo})) +
                                          ClampW'($signed({1'b0, tri_prod1_reg})));
                end
                else if (mid1_reg)
                begin
                    alt_next = clamp_code(ClampW'($signed({1'b0, c_hi})) -
                                          ClampW'($signed({1'b0, tri_prod1_reg})));
                end
                else
                begin
                    alt_next = a_lo;
                end
            end
            wts_pkg::SHAPE_PULSE:
                alt_next = pk1_reg ? c_hi : dc_level_reg;
            wts_pkg::SHAPE_DC:
                alt_next = dc_level_reg;
            wts_pkg::SHAPE_SAWTOOTH:
                alt_next = clamp_code(ClampW'($signed({1'b0, a_lo})) +
                                      ClampW'($signed({1'b0, saw_prod1_reg})));
            default:
                alt_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        fract2_reg <= {phase1_reg[Shift-1:0], {SineBits{1'b0}}};
        alt2_reg   <= alt_next;
        alt3_reg   <= alt2_reg;
        alt4_reg   <= alt3_reg;
        alt5_reg   <= alt4_reg;
    end

    // ---------------------------------------------------------------------
    // Stage 3: interpolation weights times the two entries.
    // ---------------------------------------------------------------------
    always_comb
    begin
        wgt       = wts_pkg::SIN_W'(17'h08000 - {2'b00, fract2_reg});
        p_lo_next = $signed({16'b0, wgt}) * MulW'(rom_lo);
        p_hi_next = $signed({17'b0, fract2_reg}) * MulW'(rom_hi);
    end

    always_ff @(posedge clk)
    begin
        p_lo3_reg <= p_lo_next;
        p_hi3_reg <= p_hi_next;
    end

    // ---------------------------------------------------------------------
    // Stage 4: drop the fraction of each product and double; the result
    // wraps in 16 bits, so only the low 15 bits of the sum survive.
    // ---------------------------------------------------------------------
    always_comb
    begin
        sum4      = (p_lo3_reg >>> 16) + (p_hi3_reg >>> 16);
        sin4_next = $signed({sum4[wts_pkg::SIN_W-2:0], 1'b0});
    end

    always_ff @(posedge clk)
    begin
        sin4_reg <= sin4_next;
    end

    // ---------------------------------------------------------------------
    // Stage 5: scale by the amplitude.
    // ---------------------------------------------------------------------
    assign scale_full = MulW'(sin4_reg) * $signed({20'b0, amplitude_reg});

    always_ff @(posedge clk)
    begin
        scale5_reg <= $signed(scale_full[ScaleW-1:0]);
    end

    // ---------------------------------------------------------------------
    // Stage 6: shift down by 15, add the offset, clamp; pick the sine or
    // the word formed in stage 2.
    // ---------------------------------------------------------------------
    always_comb
    begin
        level6 = dc_s + ClampW'(scale5_reg >>> 15);
        if (wave_shape_reg == wts_pkg::SHAPE_SINE)
        begin
            code6_next = clamp_code(level6);
        end
        else
        begin
            code6_next = alt5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        code6_reg <= code6_next;
    end

    assign strobe      = v6_reg;
    assign sample_code = code6_reg;

`ifndef SYNTH
    // A result leaves only for a word that was taken
    a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(accept, 6))
        else $error("result strobe without a word accepted six cycles earlier");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe |-> !$past(accept, 6))
        else $error("accepted word produced no result");

    // A word is never taken when the divider could start under it
    a_coef_steady: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !div_busy)
        else $error("divider running while a word is in flight");

    a_recalc_starts: assert property (@(posedge clk) disable iff (!rst_n)
        recalc_pend_reg |=> div_busy)
        else $error("coefficient recalculation did not start");
`endif

endmodule

// ===== tb/waveform_table_sample_unit_tb.sv =====
`timescale 1ns / 1ps
// waveform_table_sample_unit_tb.sv: self-checking bench for the waveform table sample unit.
// Needs wts_pkg and waveform_table_sample_unit; predicts every DAC code from the register set.
module waveform_table_sample_unit_tb;

    // Shape code 7 has no waveform of its own and must read as off
    localparam wts_pkg::shape_t SHAPE_UNUSED = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_WORDS = 1100;
    localparam int          SETTLE_WAIT  = 12;
    localparam longint unsigned TURN_Q30 = 64'd6746518852;

    // One directed probe: register set, index and, where obvious, the code it must give
    typedef struct packed {
        wts_pkg::shape_t shape;
        wts_pkg::code_t  offset;
        wts_pkg::code_t  ampl;
        wts_pkg::count_t points;
        wts_pkg::index_t idx;
        logic            known;
        wts_pkg::code_t  code;
    } probe_t;

    localparam probe_t PROBES [0:24] = '{
        // reset setting: sine, 2047/2047, 20 points
        '{wts_pkg::SHAPE_SINE,     12'd2047, 12'd2047, 10'd20,   9'd0,   1'b1, 12'd2047},
        '{wts_pkg::SHAPE_SINE,     12'd2047, 12'd2047, 10'd20,   9'd5,   1'b0, 12'd0},
        '{wts_pkg::SHAPE_SINE,     12'd2047, 12'd2047, 10'd20,   9'd15,  1'b0, 12'd0},
        // off and the unused code give zero
        '{wts_pkg::SHAPE_OFF,      12'd2047, 12'd2047, 10'd20,   9'd0,   1'b1, 12'd0},
        '{SHAPE_UNUSED,            12'd2047, 12'd2047, 10'd20,   9'd511, 1'b1, 12'd0},
        // dc at both rails
        '{wts_pkg::SHAPE_DC,       12'd4095, 12'd0,    10'd20,   9'd3,   1'b1, 12'd4095},
        '{wts_pkg::SHAPE_DC,       12'd0,    12'd4095, 10'd20,   9'd3,   1'b1, 12'd0},
        // square clamped at both rails on the longest period, then the shortest period
        '{wts_pkg::SHAPE_SQUARE,   12'd4095, 12'd4095, 10'd512,  9'd0,   1'b1, 12'd4095},
        '{wts_pkg::SHAPE_SQUARE,   12'd4095, 12'd4095, 10'd512,  9'd511, 1'b1, 12'd0},
        '{wts_pkg::SHAPE_SQUARE,   12'd0,    12'd0,    10'd2,    9'd1,   1'b1, 12'd0},
        // triangle: low point, peak region, falling edge, index past the period
        '{wts_pkg::SHAPE_TRIANGLE, 12'd2047, 12'd4095, 10'd512,  9'd0,   1'b1, 12'd0},
        '{wts_pkg::SHAPE_TRIANGLE, 12'd2047, 12'd4095, 10'd512,  9'd255, 1'b0, 12'd0},
        '{wts_pkg::SHAPE_TRIANGLE, 12'd2047, 12'd4095, 10'd512,  9'd300, 1'b0, 12'd0},
        '{wts_pkg::SHAPE_TRIANGLE, 12'd2047, 12'd4095, 10'd20,   9'd40,  1'b0, 12'd0},
        // pulse on a two-point period is high at index 1 and 2
        '{wts_pkg::SHAPE_PULSE,    12'd1000, 12'd500,  10'd2,    9'd2,   1'b1, 12'd1500},
        '{wts_pkg::SHAPE_PULSE,    12'd1000, 12'd500,  10'd2,    9'd1,   1'b1, 12'd1500},
        '{wts_pkg::SHAPE_PULSE,    12'd1000, 12'd500,  10'd2,    9'd0,   1'b1, 12'd1000},
        // sawtooth at full scale, then with a count below the floor
        '{wts_pkg::SHAPE_SAWTOOTH, 12'd0,    12'd4095, 10'd512,  9'd511, 1'b0, 12'd0},
        '{wts_pkg::SHAPE_SAWTOOTH, 12'd0,    12'd4095, 10'd0,    9'd511, 1'b0, 12'd0},
        // sine: count above the ceiling, odd count with phase wrap, two points
        '{wts_pkg::SHAPE_SINE,     12'd2047, 12'd4095, 10'd1023, 9'd128, 1'b0, 12'd0},
        '{wts_pkg::SHAPE_SINE,     12'd2047, 12'd4095, 10'd21,   9'd300, 1'b0, 12'd0},
        '{wts_pkg::SHAPE_SINE,     12'd0,    12'd4095, 10'd2,    9'd511, 1'b0, 12'd0},
        '{wts_pkg::SHAPE_TRIANGLE, 12'd100,  12'd3000, 10'd7,    9'd6,   1'b0, 12'd0},
        '{wts_pkg::SHAPE_SINE,     12'd4095, 12'd4095, 10'd20,   9'd5,   1'b0, 12'd0},
        '{wts_pkg::SHAPE_SINE,     12'd0,    12'd0,    10'd512,  9'd100, 1'b1, 12'd0}
    };

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    wts_pkg::index_t   sample_index = '0;
    logic              strobe;
    wts_pkg::code_t    sample_code;
    logic              cfg_write    = 1'b0;
    wts_pkg::cfg_idx_t cfg_index    = wts_pkg::REG_WAVE_SHAPE;
    logic [wts_pkg::CODE_W-1:0] cfg_data = '0;

    // Bench copy of the register set, updated at each write edge
    wts_pkg::shape_t cur_shape;
    wts_pkg::code_t  cur_offset;
    wts_pkg::code_t  cur_amplitude;
    wts_pkg::count_t cur_points;

    int sine_rom [0:wts_pkg::SINE_TABLE_SIZE];
    int sine_bits;

    wts_pkg::code_t expected_codes [$];
    int             fault_count = 0;
    int unsigned    cycle_count = 0;

    waveform_table_sample_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .strobe       (strobe),
        .sample_code  (sample_code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // round(32768*sin(2*pi*t/n)) for the first quarter turn, by a fixed-point Taylor series
    function automatic longint unsigned quarter_wave_mag(int unsigned t, int unsigned n);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        longint unsigned term;
        x    = (TURN_Q30 * t + n / 2) / n;
        x2   = (x * x) >> 30;
        acc  = x;
        term = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return (acc + 64'd16384) >> 15;
    endfunction

    // Fill the sine ROM by quarter symmetry; the positive peak saturates at 32767
    task automatic build_sine_rom();
        int tn;
        longint unsigned m;
        int pos;
        sine_bits = 2;
        while (((2 << sine_bits) <= wts_pkg::SINE_TABLE_SIZE) && (sine_bits < 14))
            sine_bits++;
        tn = 1 << sine_bits;
        for (int t = 0; t <= tn / 4; t++)
        begin
            m   = quarter_wave_mag(t, tn);
            pos = (m > 32767) ? 32767 : int'(m);
            sine_rom[t]          = pos;
            sine_rom[tn / 2 - t] = pos;
            sine_rom[tn / 2 + t] = -int'(m);
            sine_rom[tn - t]     = -int'(m);
        end
    endtask

    // Q15 sine of a 15-bit phase with linear interpolation between ROM entries
    function automatic shortint sine_at_phase(int unsigned phase);
        int unsigned x;
        int unsigned k;
        int unsigned shift;
        longint fr;
        longint lo;
        longint hi;
        longint t;
        shortint s;
        shift = 15 - sine_bits;
        x     = phase & 32'h7fff;
        k     = x >> shift;
        fr    = longint'((x - (k << shift)) << sine_bits);
        lo    = sine_rom[k];
        hi    = sine_rom[k + 1];
        t     = ((32768 - fr) * lo) >>> 16;
        s     = shortint'((t * 65536 + fr * hi) >>> 16);
        return shortint'(longint'(s) * 2);
    endfunction

    function automatic longint sat12(longint v);
        if (v < 0)
            return 0;
        if (v > wts_pkg::CODE_MAX)
            return wts_pkg::CODE_MAX;
        return v;
    endfunction

    // Expected DAC code for one index under the current register set
    function automatic wts_pkg::code_t wave_point(wts_pkg::index_t idx);
        longint i;
        longint vdc;
        longint vpp;
        longint n;
        longint h;
        longint lo_pt;
        longint hi_pt;
        longint slope;
        longint r;
        int unsigned step_sz;
        shortint s;
        i   = idx;
        vdc = cur_offset;
        vpp = cur_amplitude;
        n   = cur_points;
        if (n < 2)
            n = 2;
        if (n > wts_pkg::MAX_POINTS)
            n = wts_pkg::MAX_POINTS;
        h = n / 2;
        case (cur_shape)
            wts_pkg::SHAPE_SINE:
            begin
                step_sz = 32'h7fff / n;
                s = sine_at_phase(step_sz * int'(i));
                r = sat12(vdc + ((vpp * s) >>> 15));
            end
            wts_pkg::SHAPE_SQUARE:
                r = (i < h) ? sat12(vdc + vpp) : sat12(vdc - vpp);
            wts_pkg::SHAPE_TRIANGLE:
            begin
                lo_pt = sat12(vdc - vpp);
                hi_pt = sat12(vdc + vpp);
                slope = sat12(vpp * 2) / h;
                if (i < h)
                    r = sat12(lo_pt + slope * i);
                else if (i < 2 * h)
                    r = sat12(hi_pt - slope * (i - h));
                else
                    r = lo_pt;
            end
            wts_pkg::SHAPE_PULSE:
                r = (i == h || i == h + 1) ? sat12(vdc + vpp) : vdc;
            wts_pkg::SHAPE_DC:
                r = vdc;
            wts_pkg::SHAPE_SAWTOOTH:
            begin
                lo_pt = sat12(vdc - vpp);
                slope = sat12(vpp * 2) / n;
                r = sat12(lo_pt + slope * i);
            end
            default:
                r = 0;
        endcase
        return wts_pkg::code_t'(r);
    endfunction

    task automatic report_fault(string what, wts_pkg::code_t want, wts_pkg::code_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("ERROR: %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    // Write one register and mirror it; the caller drops the enable after its last write
    task automatic write_reg(wts_pkg::cfg_idx_t idx, logic [wts_pkg::CODE_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            wts_pkg::REG_WAVE_SHAPE:  cur_shape     = val[wts_pkg::SHAPE_W-1:0];
            wts_pkg::REG_DC_LEVEL:    cur_offset    = val;
            wts_pkg::REG_AMPLITUDE:   cur_amplitude = val;
            wts_pkg::REG_POINT_COUNT: cur_points    = val[wts_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one word and hold start until the block takes it, then queue its code
    task automatic send_word(wts_pkg::index_t idx, logic known, wts_pkg::code_t code);
        sample_index <= idx;
        start        <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        expected_codes.push_back(known ? code : wave_point(idx));
    endtask

    // Sender gap after a word; a steady stretch leaves start high
    task automatic hold_off(bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold until every queued code has come back
    task automatic wait_for_codes();
        if (start)
            start <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
    endtask

    // Result side: a code can appear on any cycle and must be taken there and then
    always @(posedge clk)
    begin : code_check
        wts_pkg::code_t want;
        if (rst_n && strobe !== 1'b0)
        begin
            if (expected_codes.size() == 0)
            begin
                report_fault("unexpected sample_code", '0, sample_code);
            end
            else
            begin
                want = expected_codes.pop_front();
                if (sample_code !== want)
                    report_fault("sample_code mismatch", want, sample_code);
            end
        end
    end

    // Watchdog: count cycles and stop a run that has hung
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("waveform_table_sample_unit test failed");
        $finish;
    end

    initial
    begin : stimulus
        probe_t row;
        int random_words;
        int words;
        int n;
        bit steady;
        bit wrote;
        logic [wts_pkg::CODE_W-1:0] cfg_word;
        wts_pkg::index_t idx;

        build_sine_rom();
        cur_shape     = wts_pkg::RST_WAVE_SHAPE;
        cur_offset    = wts_pkg::RST_DC_LEVEL;
        cur_amplitude = wts_pkg::RST_AMPLITUDE;
        cur_points    = wts_pkg::RST_POINT_COUNT;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed probes: rewrite the register set only where a row changes it
        for (int p = 0; p < 25; p++)
        begin
            row = PROBES[p];
            if (row.shape != cur_shape || row.offset != cur_offset ||
                row.ampl != cur_amplitude || row.points != cur_points)
            begin
                wait_for_codes();
                write_reg(wts_pkg::REG_WAVE_SHAPE, wts_pkg::CODE_W'(row.shape));
                write_reg(wts_pkg::REG_DC_LEVEL, row.offset);
                write_reg(wts_pkg::REG_AMPLITUDE, row.ampl);
                write_reg(wts_pkg::REG_POINT_COUNT, wts_pkg::CODE_W'(row.points));
                cfg_write <= 1'b0;
            end
            send_word(row.idx, row.known, row.code);
            hold_off(1'b0);
        end

        // Random phases: new register set when idle, then a burst of indexes
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            wait_for_codes();
            wrote = 1'b0;
            if ($urandom_range(0, 3) != 0)
            begin
                // upper data bits are random too; only the low three count
                write_reg(wts_pkg::REG_WAVE_SHAPE,
                          wts_pkg::CODE_W'($urandom_range(0, 4095)));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 3))
                    0:       cfg_word = '0;
                    1:       cfg_word = wts_pkg::CODE_W'(wts_pkg::CODE_MAX);
                    default: cfg_word = wts_pkg::CODE_W'($urandom_range(0, 4095));
                endcase
                write_reg(wts_pkg::REG_DC_LEVEL, cfg_word);
                wrote = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 3))
                    0:       cfg_word = '0;
                    1:       cfg_word = wts_pkg::CODE_W'(wts_pkg::CODE_MAX);
                    default: cfg_word = wts_pkg::CODE_W'($urandom_range(0, 4095));
                endcase
                write_reg(wts_pkg::REG_AMPLITUDE, cfg_word);
                wrote = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                cfg_word = wts_pkg::CODE_W'($urandom_range(0, 4095));
                // bias the count: mostly even periods, some small, odd or out of range
                case ($urandom_range(0, 9))
                    6:
                        cfg_word[wts_pkg::CNT_W-1:0] =
                            wts_pkg::CNT_W'(2 * $urandom_range(1, 8));
                    7:
                        cfg_word[wts_pkg::CNT_W-1:0] =
                            wts_pkg::CNT_W'(2 * $urandom_range(1, 255) + 1);
                    8:
                        cfg_word[wts_pkg::CNT_W-1:0] =
                            wts_pkg::CNT_W'($urandom_range(0, 1));
                    9:
                        cfg_word[wts_pkg::CNT_W-1:0] =
                            wts_pkg::CNT_W'($urandom_range(513, 1023));
                    default:
                        cfg_word[wts_pkg::CNT_W-1:0] =
                            wts_pkg::CNT_W'(2 * $urandom_range(1, 256));
                endcase
                write_reg(wts_pkg::REG_POINT_COUNT, cfg_word);
                wrote = 1'b1;
            end
            if (wrote)
                cfg_write <= 1'b0;

            n = cur_points;
            if (n < 2)
                n = 2;
            if (n > wts_pkg::MAX_POINTS)
                n = wts_pkg::MAX_POINTS;
            steady = ($urandom_range(0, 3) == 0);
            words  = $urandom_range(10, 40);
            repeat (words)
            begin
                // mostly inside the period, the rest anywhere in the index range
                if ($urandom_range(0, 3) != 0)
                    idx = wts_pkg::index_t'($urandom_range(0, n - 1));
                else
                    idx = wts_pkg::index_t'($urandom_range(0, 511));
                send_word(idx, 1'b0, '0);
                random_words++;
                hold_off(steady);
                // now and then let the pipeline run dry before the next word
                if ($urandom_range(0, 39) == 0)
                    wait_for_codes();
            end
        end

        wait_for_codes();
        repeat (SETTLE_WAIT) @(posedge clk);

        if (fault_count == 0)
            $display("waveform_table_sample_unit test passed");
        else
            $display("waveform_table_sample_unit test failed");
        $finish;
    end

endmodule
